// File: sv/boundary_layer_classifier_assert.svh
// assertion macros shared by the checker file
`ifndef BOUNDARY_LAYER_CLASSIFIER_ASSERT_SVH
`define BOUNDARY_LAYER_CLASSIFIER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define BLC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("blc check failed in %m");

// consequent must hold in the cycle after the antecedent
`define BLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("blc check failed in %m");

`endif

// File: sv/blc_pkg.sv
package blc_pkg;

	localparam int NUM_LAYERS    = 7;
	localparam int MAX_KEYPOINTS = 32;
	localparam int COORD_WIDTH   = 32;

	localparam int NUM_BOUNDS  = NUM_LAYERS - 1;
	localparam int STORE_DEPTH = NUM_BOUNDS * MAX_KEYPOINTS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int KP_W        = $clog2(MAX_KEYPOINTS);
	localparam int BND_W       = $clog2(NUM_LAYERS);
	localparam int DIST_W      = COORD_WIDTH + 1;
	localparam int PROD_W      = 2 * DIST_W;

	// fixed field widths
	localparam int BI_W     = 3;
	localparam int PI_W     = 5;
	localparam int LAYER_W  = 3;
	localparam int STATUS_W = 2;
	localparam int BLANK_W  = 32;

	localparam logic OP_LOAD     = 1'b0;
	localparam logic OP_CLASSIFY = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_LEFT = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FEW_KP   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_ORDER,
		ST_DIFF,
		ST_MUL1,
		ST_MUL2,
		ST_CMP
	} state_t;

endpackage

// File: sv/boundary_layer_classifier.sv
// load request: busy stays low; no result
// classify request: for each boundary examined, the keypoints are read one by one from the
// keypoint memory, the search pipeline drains, then the cross test runs on the shared
// multiplier (order, diff, mul1, mul2, compare); at most six boundaries are examined
// one request at a time; the receiver cannot stall, done lasts one cycle
// asynchronous active-low reset clears the loaded bits, the register and the sequencer
module boundary_layer_classifier import blc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       op,
	input  logic [BI_W-1:0]            boundary_index,
	input  logic [PI_W-1:0]            point_index,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	output logic                       done,
	output logic [LAYER_W-1:0]         layer_number,
	output logic [STATUS_W-1:0]        status,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic signed [BLANK_W-1:0]  cfg_data
);

	// sequencer
	state_t state_q, state_nxt;

	// keypoint memories, loaded bit per entry in flops
	logic signed [COORD_WIDTH-1:0] x_mem [STORE_DEPTH];
	logic signed [COORD_WIDTH-1:0] y_mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0]        loaded_q;

	logic signed [BLANK_W-1:0] blank_q;

	// query point
	logic signed [COORD_WIDTH-1:0] px_q, py_q;

	// scan counters
	logic [ADDR_W-1:0] addr_q;
	logic [KP_W-1:0]   kp_q;
	logic [BND_W-1:0]  bnd_q;

	// search pipeline: memory read, distance, ranking
	logic                          v_s1, ok_s1;
	logic signed [COORD_WIDTH-1:0] x_s1, y_s1;
	logic                          cand_s2;
	logic [DIST_W-1:0]             d_s2;
	logic signed [COORD_WIDTH-1:0] x_s2, y_s2;

	// two nearest keypoints so far
	logic                          v1_q, v2_q;
	logic [DIST_W-1:0]             d1_q, d2_q;
	logic signed [COORD_WIDTH-1:0] c1x_q, c1y_q, c2x_q, c2y_q;

	// cross test
	logic signed [COORD_WIDTH-1:0] ax_q, ay_q, bx_q, by_q;
	logic signed [DIST_W-1:0]      dbx_q, dpy_q, dby_q, dpx_q;
	logic signed [PROD_W-1:0]      p1_q, p2_q;

	// control
	logic ld_en, ld_in_range, cls_acc, rd_en, clr_cand;
	logic kp_last, bnd_last, pipe_empty, neg;
	logic res_few, res_hit, res_end, next_bnd;
	logic upd1, upd2;
	logic [ADDR_W-1:0] ld_addr;

	// shared multiplier
	logic signed [DIST_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_res;

	logic signed [DIST_W-1:0] dy_s1;
	logic done_q;
	logic [LAYER_W-1:0]  layer_q;
	logic [STATUS_W-1:0] status_q;

	assign cfg_ready = 1'b1;

	assign ld_in_range = (int'(boundary_index) < NUM_BOUNDS) &&
	                     (int'(point_index) < MAX_KEYPOINTS);
	assign ld_addr = ADDR_W'(int'(boundary_index) * MAX_KEYPOINTS + int'(point_index));

	assign kp_last    = (kp_q == KP_W'(MAX_KEYPOINTS - 1));
	assign bnd_last   = (bnd_q == BND_W'(NUM_BOUNDS - 1));
	assign pipe_empty = !v_s1 && !cand_s2;

	// point right of the boundary when the cross product is negative
	assign neg = (p1_q < p2_q);

	// strict less-than keeps the earlier slot on equal distance
	assign upd1 = cand_s2 && (!v1_q || (d_s2 < d1_q));
	assign upd2 = cand_s2 && !upd1 && (!v2_q || (d_s2 < d2_q));

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && op == OP_CLASSIFY)
					state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (kp_last)
					state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (pipe_empty)
					state_nxt = v2_q ? ST_ORDER : ST_IDLE;
			end
			ST_ORDER: state_nxt = ST_DIFF;
			ST_DIFF:  state_nxt = ST_MUL1;
			ST_MUL1:  state_nxt = ST_MUL2;
			ST_MUL2:  state_nxt = ST_CMP;
			ST_CMP: begin
				if (neg || bnd_last)
					state_nxt = ST_IDLE;
				else
					state_nxt = ST_SCAN;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy     = (state_q != ST_IDLE);
		ld_en    = (state_q == ST_IDLE) && start && (op == OP_LOAD) && ld_in_range;
		cls_acc  = (state_q == ST_IDLE) && start && (op == OP_CLASSIFY);
		rd_en    = (state_q == ST_SCAN);
		res_few  = (state_q == ST_DRAIN) && pipe_empty && !v2_q;
		res_hit  = (state_q == ST_CMP) && neg;
		res_end  = (state_q == ST_CMP) && !neg && bnd_last;
		next_bnd = (state_q == ST_CMP) && !neg && !bnd_last;
		clr_cand = cls_acc || next_bnd;
		// first product in the first step, second product in the next
		if (state_q == ST_MUL2) begin
			mul_a = dby_q;
			mul_b = dpx_q;
		end else begin
			mul_a = dbx_q;
			mul_b = dpy_q;
		end
	end

	assign mul_res = mul_a * mul_b;

	// distance in y, widened by one bit so it never overflows
	assign dy_s1 = {py_q[COORD_WIDTH-1], py_q} - {y_s1[COORD_WIDTH-1], y_s1};

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			loaded_q <= '0;
			blank_q  <= '0;
			addr_q   <= '0;
			kp_q     <= '0;
			bnd_q    <= '0;
			v_s1     <= 1'b0;
			ok_s1    <= 1'b0;
			cand_s2  <= 1'b0;
			v1_q     <= 1'b0;
			v2_q     <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid && cfg_ready)
				blank_q <= cfg_data;
			if (ld_en)
				loaded_q[ld_addr] <= 1'b1;

			// addresses run straight through the boundaries in order
			if (cls_acc) begin
				addr_q <= '0;
				kp_q   <= '0;
				bnd_q  <= '0;
			end else if (rd_en) begin
				addr_q <= addr_q + ADDR_W'(1);
				kp_q   <= kp_q + KP_W'(1);
			end else if (next_bnd) begin
				bnd_q <= bnd_q + BND_W'(1);
			end

			v_s1    <= rd_en;
			ok_s1   <= rd_en && loaded_q[addr_q];
			cand_s2 <= v_s1 && ok_s1 && (x_s1 != blank_q);

			if (clr_cand) begin
				v1_q <= 1'b0;
				v2_q <= 1'b0;
			end else if (upd1) begin
				v1_q <= 1'b1;
				v2_q <= v1_q;
			end else if (upd2) begin
				v2_q <= 1'b1;
			end

			done_q <= res_few || res_hit || res_end;
		end
	end

	// keypoint memories
	always_ff @(posedge clk) begin
		if (ld_en) begin
			x_mem[ld_addr] <= coord_x;
			y_mem[ld_addr] <= coord_y;
		end
		if (rd_en) begin
			x_s1 <= x_mem[addr_q];
			y_s1 <= y_mem[addr_q];
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (cls_acc) begin
			px_q <= coord_x;
			py_q <= coord_y;
		end

		d_s2 <= dy_s1[DIST_W-1] ? DIST_W'(-dy_s1) : DIST_W'(dy_s1);
		x_s2 <= x_s1;
		y_s2 <= y_s1;

		// nearest drops to second place when beaten
		if (upd1) begin
			d2_q  <= d1_q;
			c2x_q <= c1x_q;
			c2y_q <= c1y_q;
			d1_q  <= d_s2;
			c1x_q <= x_s2;
			c1y_q <= y_s2;
		end else if (upd2) begin
			d2_q  <= d_s2;
			c2x_q <= x_s2;
			c2y_q <= y_s2;
		end

		// order by x, swap only when the nearest is strictly larger
		if (state_q == ST_ORDER) begin
			if (c1x_q > c2x_q) begin
				ax_q <= c2x_q;
				ay_q <= c2y_q;
				bx_q <= c1x_q;
				by_q <= c1y_q;
			end else begin
				ax_q <= c1x_q;
				ay_q <= c1y_q;
				bx_q <= c2x_q;
				by_q <= c2y_q;
			end
		end

		if (state_q == ST_DIFF) begin
			dbx_q <= {bx_q[COORD_WIDTH-1], bx_q} - {ax_q[COORD_WIDTH-1], ax_q};
			dpy_q <= {py_q[COORD_WIDTH-1], py_q} - {ay_q[COORD_WIDTH-1], ay_q};
			dby_q <= {by_q[COORD_WIDTH-1], by_q} - {ay_q[COORD_WIDTH-1], ay_q};
			dpx_q <= {px_q[COORD_WIDTH-1], px_q} - {ax_q[COORD_WIDTH-1], ax_q};
		end

		if (state_q == ST_MUL1)
			p1_q <= mul_res;
		if (state_q == ST_MUL2)
			p2_q <= mul_res;

		// result registers
		if (res_few) begin
			layer_q  <= '0;
			status_q <= STATUS_FEW_KP;
		end else if (res_hit) begin
			layer_q  <= LAYER_W'(bnd_q + BND_W'(1));
			status_q <= STATUS_OK;
		end else if (res_end) begin
			layer_q  <= LAYER_W'(NUM_LAYERS);
			status_q <= STATUS_OK;
		end
	end

	assign done         = done_q;
	assign layer_number = layer_q;
	assign status       = status_q;

endmodule

// File: sv/blc_checker.sv
`include "boundary_layer_classifier_assert.svh"

module blc_checker import blc_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                op,
	input logic                done,
	input logic [LAYER_W-1:0]  layer_number,
	input logic [STATUS_W-1:0] status
);

	// a classify request always occupies the block
	`BLC_ASSERT_NEXT(a_classify_busy, clk, arst_n, start && !busy && op == OP_CLASSIFY, busy)

	// a load request gives no result and leaves the block free
	`BLC_ASSERT_NEXT(a_load_quiet, clk, arst_n, start && !busy && op == OP_LOAD, !busy && !done)

	// a result ends a busy stretch
	`BLC_ASSERT_SAME(a_done_ends_busy, clk, arst_n, done, $past(busy) && !busy)

	// errors carry layer zero, and the only error reported is too few keypoints
	`BLC_ASSERT_SAME(a_error_layer, clk, arst_n, done && status != STATUS_OK, layer_number == '0 && status == STATUS_FEW_KP)

endmodule

bind boundary_layer_classifier blc_checker u_blc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.op           (op),
	.done         (done),
	.layer_number (layer_number),
	.status       (status)
);
